// ===== rtl/mfep_pkg.sv =====
// ---------------------------------------------------------------------------
// mfep_pkg
// Shared types and constants of the midi file event parser.
// ---------------------------------------------------------------------------
package mfep_pkg;

  typedef enum logic [2:0] {
    KIND_CHANNEL = 3'd0,
    KIND_TEMPO   = 3'd1,
    KIND_CMD     = 3'd2,
    KIND_HDR_OK  = 3'd3,
    KIND_HDR_ERR = 3'd4,
    KIND_END     = 3'd5,
    KIND_UNKNOWN = 3'd6
  } kind_e;

  typedef enum logic [18:0] {
    PH_MAGIC1   = 19'h00001,
    PH_RIFFSKIP = 19'h00002,
    PH_MAGIC2   = 19'h00004,
    PH_HSIZE    = 19'h00008,
    PH_FORMAT   = 19'h00010,
    PH_NTRK     = 19'h00020,
    PH_DIV      = 19'h00040,
    PH_MTRK     = 19'h00080,
    PH_TLEN     = 19'h00100,
    PH_DELTA    = 19'h00200,
    PH_STATUS   = 19'h00400,
    PH_DATA1    = 19'h00800,
    PH_DATA2    = 19'h01000,
    PH_METATYPE = 19'h02000,
    PH_METALEN  = 19'h04000,
    PH_METASKIP = 19'h08000,
    PH_SYXLEN   = 19'h10000,
    PH_SYXSKIP  = 19'h20000,
    PH_DONE     = 19'h40000
  } phase_e;

  localparam logic [31:0] MagicRiff = 32'h52494646;
  localparam logic [31:0] MagicMthd = 32'h4d546864;
  localparam logic [31:0] MagicMtrk = 32'h4d54726b;
  localparam logic [7:0]  MetaEnd   = 8'h2f;
  localparam logic [7:0]  MetaTempo = 8'h51;
  localparam logic [3:0]  CtrlNib   = 4'hb;
  localparam logic [6:0]  CcDataMsb = 7'h06;
  localparam logic [6:0]  CcDataLsb = 7'h26;
  localparam logic [6:0]  CcRpnLsb  = 7'h64;
  localparam logic [6:0]  CcRpnMsb  = 7'h65;
  localparam logic [6:0]  RpnNull   = 7'h7f;
  localparam logic [7:0]  StMeta    = 8'hff;
  localparam logic [7:0]  StSysex   = 8'hf0;
  localparam logic [7:0]  StEscape  = 8'hf7;

  // one result item
  typedef struct packed {
    kind_e       kind;
    logic [31:0] event_time;
    logic [19:0] event_index;
    logic [7:0]  status_byte;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [23:0] tempo_value;
    logic [6:0]  command_number;
    logic [6:0]  command_value;
    logic [15:0] ticks_division;
    logic        last_of_run;
  } result_t;

  // data bytes needed by a channel status nibble
  function automatic logic [1:0] data_count(input logic [3:0] nib);
    case (nib)
      4'h8, 4'h9, 4'ha, 4'hb, 4'he: data_count = 2'd2;
      4'hc, 4'hd:                   data_count = 2'd1;
      default:                      data_count = 2'd0;
    endcase
  endfunction

endpackage

// ===== rtl/midi_file_event_parser.sv =====
// ---------------------------------------------------------------------------
// midi_file_event_parser
// Format 0 standard midi file byte parser giving timed track events.
// ---------------------------------------------------------------------------
//  channel | direction | signals
//  input   | in        | in_valid_i, in_stall_o, data_byte_i, end_of_data_i
//  output  | out       | out_valid_o, out_stall_i, kind_o .. last_of_run_o
//
// A byte is decoded in the cycle it is accepted; its results (zero to two)
// leave from a two-entry output queue, one per cycle, from the next cycle on.
// Unstalled, a byte giving one result sustains one byte per cycle; after two,
// input waits for the last to go. Reset clears all parse state to the header
// search. Output stall holds the queue and stalls input once it cannot drain.
module midi_file_event_parser import mfep_pkg::*; #(
  parameter int INDEX_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] event_time_o,
  output logic [19:0] event_index_o,
  output logic [7:0]  status_byte_o,
  output logic [6:0]  first_data_o,
  output logic [6:0]  second_data_o,
  output logic [23:0] tempo_value_o,
  output logic [6:0]  command_number_o,
  output logic [6:0]  command_value_o,
  output logic [15:0] ticks_division_o,
  output logic        last_of_run_o
);

  logic ready, step;
  logic [1:0] cnt;
  result_t r0, r1, ro;

  assign in_stall_o = !ready;
  assign step = in_valid_i && ready;

  mfep_core #(.IndexBits(INDEX_BITS)) u_core (
    .clk_i, .rst_ni, .step_i(step), .byte_i(data_byte_i), .eod_i(end_of_data_i),
    .count_o(cnt), .res0_o(r0), .res1_o(r1)
  );

  mfep_out_queue u_queue (
    .clk_i, .rst_ni, .load_i(step), .count_i(cnt), .res0_i(r0), .res1_i(r1),
    .ready_o(ready), .valid_o(out_valid_o), .stall_i(out_stall_i), .res_o(ro)
  );

  assign kind_o           = ro.kind;
  assign event_time_o     = ro.event_time;
  assign event_index_o    = ro.event_index;
  assign status_byte_o    = ro.status_byte;
  assign first_data_o     = ro.first_data;
  assign second_data_o    = ro.second_data;
  assign tempo_value_o    = ro.tempo_value;
  assign command_number_o = ro.command_number;
  assign command_value_o  = ro.command_value;
  assign ticks_division_o = ro.ticks_division;
  assign last_of_run_o    = ro.last_of_run;

endmodule

// ===== rtl/mfep_core.sv =====
// ---------------------------------------------------------------------------
// mfep_core
// Parser state and the per-byte decode; gives up to two results per byte.
// ---------------------------------------------------------------------------
module mfep_core import mfep_pkg::*; #(
  parameter int IndexBits = 20
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic [7:0] byte_i,
  input  logic    eod_i,
  output logic [1:0] count_o,
  output result_t res0_o,
  output result_t res1_o
);

  localparam logic [IndexBits-1:0] IdxMax = {IndexBits{1'b1}};
  localparam int CmdEvents = 6;

  phase_e phase_q, phase_d;
  logic [4:0]  fcnt_q, fcnt_d;
  logic [31:0] fsh_q, fsh_d, atime_q, atime_d, trem_q, trem_d;
  logic [7:0]  stat_q, stat_d, meta_q, meta_d;
  logic [6:0]  pend_q, pend_d, ccmd_q, ccmd_d, cval_q, cval_d;
  logic [27:0] lacc_q, lacc_d, skip_q, skip_d;
  logic [2:0]  prog_q, prog_d;
  logic [IndexBits-1:0] evs_q, evs_d;
  logic        run_q, run_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC1; fcnt_q <= '0; fsh_q <= '0; atime_q <= '0;
      trem_q <= '1; stat_q <= '0; meta_q <= '0; pend_q <= '0;
      ccmd_q <= '0; cval_q <= '0; lacc_q <= '0; skip_q <= '0;
      prog_q <= '0; evs_q <= '0; run_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d; fcnt_q <= fcnt_d; fsh_q <= fsh_d; atime_q <= atime_d;
      trem_q <= trem_d; stat_q <= stat_d; meta_q <= meta_d; pend_q <= pend_d;
      ccmd_q <= ccmd_d; cval_q <= cval_d; lacc_q <= lacc_d; skip_q <= skip_d;
      prog_q <= prog_d; evs_q <= evs_d; run_q <= run_d;
    end
  end

  logic [31:0] col_sh;
  logic [4:0]  col_cnt;
  logic [31:0] dsum;
  logic [32:0] dsum_w;
  logic [27:0] vlq_acc, skip_dec;
  logic [1:0]  need;
  logic        chan, is_run;
  logic [6:0]  d1, d2;
  logic [31:0] tempo_sh;
  logic [4:0]  tempo_k;
  logic [IndexBits-1:0] idx_now;
  logic [IndexBits:0]   top_w;
  logic        pat_hit;
  logic [2:0]  pstep;
  result_t     r [2];
  logic [1:0]  n;

  assign col_sh  = {fsh_q[23:0], byte_i};
  assign col_cnt = fcnt_q + 5'd1;
  assign vlq_acc = {lacc_q[20:0], byte_i[6:0]};
  assign skip_dec = skip_q - 28'd1;
  assign idx_now = evs_q;
  assign top_w   = {1'b0, evs_q} + 1'b1;

  function automatic result_t blank();
    result_t b;
    b = '0;
    return b;
  endfunction

  always_comb begin
    phase_d = phase_q; fcnt_d = fcnt_q; fsh_d = fsh_q; atime_d = atime_q;
    trem_d = trem_q; stat_d = stat_q; meta_d = meta_q; pend_d = pend_q;
    ccmd_d = ccmd_q; cval_d = cval_q; lacc_d = lacc_q; skip_d = skip_q;
    prog_d = prog_q; evs_d = evs_q; run_d = run_q;
    r[0] = blank(); r[1] = blank(); n = 2'd0;
    dsum_w = '0; dsum = '0; need = '0; is_run = 1'b0; d1 = '0; d2 = '0;
    chan = 1'b0; tempo_sh = '0; tempo_k = '0; pat_hit = 1'b0; pstep = '0;

    // track length countdown
    if (phase_q != PH_DONE && phase_q >= PH_DELTA && trem_q != 0)
      trem_d = trem_q - 32'd1;

    case (phase_q)
      PH_MAGIC1, PH_MAGIC2, PH_HSIZE, PH_FORMAT, PH_NTRK, PH_DIV,
      PH_MTRK, PH_TLEN: begin
        fsh_d = col_sh;
        fcnt_d = col_cnt;
        if ((phase_q == PH_FORMAT || phase_q == PH_NTRK || phase_q == PH_DIV)
            ? (col_cnt >= 5'd2) : (col_cnt >= 5'd4)) begin
          fcnt_d = '0;
          case (phase_q)
            PH_MAGIC1: begin
              if (col_sh == MagicRiff) phase_d = PH_RIFFSKIP;
              else if (col_sh == MagicMthd) phase_d = PH_HSIZE;
              else begin r[0].kind = KIND_HDR_ERR; n = 2'd1; phase_d = PH_DONE; end
            end
            PH_MAGIC2: begin
              if (col_sh == MagicMthd) phase_d = PH_HSIZE;
              else begin r[0].kind = KIND_HDR_ERR; n = 2'd1; phase_d = PH_DONE; end
            end
            PH_HSIZE: begin
              if (col_sh == 32'd6) phase_d = PH_FORMAT;
              else begin r[0].kind = KIND_HDR_ERR; n = 2'd1; phase_d = PH_DONE; end
            end
            PH_FORMAT: begin
              if (col_sh[15:0] == 16'd0) phase_d = PH_NTRK;
              else begin r[0].kind = KIND_HDR_ERR; n = 2'd1; phase_d = PH_DONE; end
            end
            PH_NTRK: begin
              if (col_sh[15:0] == 16'd1) phase_d = PH_DIV;
              else begin r[0].kind = KIND_HDR_ERR; n = 2'd1; phase_d = PH_DONE; end
            end
            PH_DIV: begin
              lacc_d = {12'd0, col_sh[15:0]};
              phase_d = PH_MTRK;
            end
            PH_MTRK: begin
              if (col_sh == MagicMtrk) phase_d = PH_TLEN;
              else begin r[0].kind = KIND_HDR_ERR; n = 2'd1; phase_d = PH_DONE; end
            end
            default: begin
              trem_d = col_sh;
              r[0].kind = KIND_HDR_OK;
              r[0].ticks_division = lacc_q[15:0];
              n = 2'd1;
              lacc_d = '0;
              fsh_d = '0;
              phase_d = (col_sh == 0) ? PH_DONE : PH_DELTA;
            end
          endcase
        end
      end
      PH_RIFFSKIP: begin
        fcnt_d = col_cnt;
        if (col_cnt >= 5'd16) begin fcnt_d = '0; phase_d = PH_MAGIC2; end
      end
      PH_DELTA: begin
        fsh_d = {fsh_q[24:0], byte_i[6:0]};
        if (!byte_i[7]) begin
          dsum_w = {1'b0, atime_q} + {1'b0, fsh_d};
          dsum = dsum_w[32] ? '1 : dsum_w[31:0];
          atime_d = dsum;
          fsh_d = '0;
          phase_d = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (byte_i[7]) begin stat_d = byte_i; run_d = 1'b0; end
        else run_d = 1'b1;
        is_run = !byte_i[7];
        need = data_count(stat_d[7:4]);
        if (need != 0) begin
          if (is_run) begin
            pend_d = byte_i[6:0];
            if (need == 2'd1) begin chan = 1'b1; d1 = byte_i[6:0]; d2 = '0; end
            else phase_d = PH_DATA2;
          end else phase_d = PH_DATA1;
        end else begin
          prog_d = '0;
          if (byte_i == StMeta) phase_d = PH_METATYPE;
          else if (byte_i == StSysex || byte_i == StEscape) begin
            lacc_d = '0; phase_d = PH_SYXLEN;
          end else begin
            r[0].kind = KIND_UNKNOWN; r[0].event_time = atime_q;
            r[0].status_byte = byte_i; n = 2'd1;
            fsh_d = '0; fcnt_d = '0;
            phase_d = (trem_d == 0) ? PH_DONE : PH_DELTA;
          end
        end
      end
      PH_DATA1: begin
        pend_d = byte_i[6:0];
        if (data_count(stat_q[7:4]) == 2'd1) begin
          chan = 1'b1; d1 = byte_i[6:0]; d2 = '0;
        end else phase_d = PH_DATA2;
      end
      PH_DATA2: begin
        chan = 1'b1; d1 = pend_q; d2 = byte_i[6:0];
      end
      PH_METATYPE: begin
        meta_d = byte_i; lacc_d = '0; phase_d = PH_METALEN;
      end
      PH_METALEN: begin
        lacc_d = vlq_acc;
        if (!byte_i[7]) begin
          if (meta_q == MetaEnd) begin
            r[0].kind = KIND_END; r[0].event_time = atime_q; n = 2'd1;
            phase_d = PH_DONE;
          end else begin
            skip_d = vlq_acc; fsh_d = '0; fcnt_d = '0;
            if (vlq_acc == 0) begin
              if (meta_q == MetaTempo) begin
                r[0].kind = KIND_TEMPO; r[0].event_time = atime_q;
                r[0].event_index = 20'(idx_now); n = 2'd1;
                if (evs_q != IdxMax) evs_d = evs_q + 1'b1;
              end
              phase_d = (trem_d == 0) ? PH_DONE : PH_DELTA;
            end else phase_d = PH_METASKIP;
          end
        end
      end
      PH_METASKIP: begin
        skip_d = skip_dec;
        tempo_sh = fsh_q; tempo_k = fcnt_q;
        if (meta_q == MetaTempo && fcnt_q < 5'd3) begin
          tempo_sh = col_sh; tempo_k = col_cnt;
          fsh_d = col_sh; fcnt_d = col_cnt;
        end
        if (meta_q == MetaTempo && fcnt_q < 5'd3 &&
            (tempo_k == 5'd3 || skip_dec == 0)) begin
          r[0].kind = KIND_TEMPO; r[0].event_time = atime_q;
          r[0].event_index = 20'(idx_now); n = 2'd1;
          if (evs_q != IdxMax) evs_d = evs_q + 1'b1;
          case (tempo_k)
            5'd1:    r[0].tempo_value = {tempo_sh[7:0], 16'd0};
            5'd2:    r[0].tempo_value = {tempo_sh[15:0], 8'd0};
            default: r[0].tempo_value = tempo_sh[23:0];
          endcase
        end
        if (skip_dec == 0) begin
          fsh_d = '0; fcnt_d = '0;
          phase_d = (trem_d == 0) ? PH_DONE : PH_DELTA;
        end
      end
      PH_SYXLEN: begin
        lacc_d = vlq_acc;
        if (!byte_i[7]) begin
          skip_d = vlq_acc;
          if (vlq_acc == 0) begin
            fsh_d = '0; fcnt_d = '0;
            phase_d = (trem_d == 0) ? PH_DONE : PH_DELTA;
          end else phase_d = PH_SYXSKIP;
        end
      end
      PH_SYXSKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 0) begin
          fsh_d = '0; fcnt_d = '0;
          phase_d = (trem_d == 0) ? PH_DONE : PH_DELTA;
        end
      end
      default: ;
    endcase

    // channel event and command pattern tracking
    if (chan) begin
      r[0].kind = KIND_CHANNEL; r[0].event_time = atime_d;
      r[0].event_index = 20'(idx_now); r[0].status_byte = stat_d;
      r[0].first_data = d1; r[0].second_data = d2; n = 2'd1;
      if (evs_q != IdxMax) evs_d = evs_q + 1'b1;
      if (stat_d[7:4] != CtrlNib) prog_d = '0;
      else begin
        pstep = prog_q + 3'd1;
        prog_d = '0;
        case (pstep)
          3'd1: if (d1 == CcRpnMsb && d2 == CcRpnLsb) prog_d = pstep;
          3'd2: if (d1 == CcRpnLsb) begin prog_d = pstep; ccmd_d = d2; end
          3'd3: if (d1 == CcDataMsb) begin prog_d = pstep; cval_d = d2; end
          3'd4: if (d1 == CcDataLsb) prog_d = pstep;
          3'd5: if (d1 == CcRpnMsb && d2 == RpnNull) prog_d = pstep;
          3'd6: pat_hit = (d1 == CcRpnLsb && d2 == RpnNull);
          default: ;
        endcase
      end
      if (pat_hit) begin
        r[1].kind = KIND_CMD; r[1].event_time = atime_d;
        r[1].event_index = (top_w >= (IndexBits+1)'(CmdEvents))
                           ? 20'(top_w - (IndexBits+1)'(CmdEvents)) : 20'd0;
        r[1].command_number = ccmd_d; r[1].command_value = cval_d;
        n = 2'd2;
      end
      fsh_d = '0; fcnt_d = '0;
      phase_d = (trem_d == 0) ? PH_DONE : PH_DELTA;
    end

    // end of data: if in header and no result, header error; reset state
    if (eod_i) begin
      if (phase_q < PH_DELTA && phase_d < PH_DELTA && n == 2'd0) begin
        r[0].kind = KIND_HDR_ERR; n = 2'd1;
      end
      phase_d = PH_MAGIC1; fcnt_d = '0; fsh_d = '0; atime_d = '0;
      trem_d = '1; stat_d = '0; meta_d = '0; pend_d = '0;
      ccmd_d = '0; cval_d = '0; lacc_d = '0; skip_d = '0;
      prog_d = '0; evs_d = '0; run_d = 1'b0;
    end
    if (n == 2'd1) r[0].last_of_run = 1'b1;
    if (n == 2'd2) r[1].last_of_run = 1'b1;
  end

  assign count_o = n;
  assign res0_o  = r[0];
  assign res1_o  = r[1];

  // the second result is always a command following a channel event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_o == 2'd2 |-> res0_o.kind == KIND_CHANNEL && res1_o.kind == KIND_CMD)
    else $error("second result without channel event");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q)) else $error("phase not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !eod_i && phase_q == PH_DONE |=> phase_q == PH_DONE)
    else $error("left done phase without end of data");

endmodule

// ===== rtl/mfep_out_queue.sv =====
// ---------------------------------------------------------------------------
// mfep_out_queue
// Holds the results of one byte and sends them out one per cycle unless stalled.
// ---------------------------------------------------------------------------
module mfep_out_queue import mfep_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  logic [1:0] count_i,
  input  result_t res0_i,
  input  result_t res1_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t res_o
);

  result_t slot_q [2];
  logic [1:0] cnt_q;
  logic pop;

  assign valid_o = cnt_q != 2'd0;
  assign pop     = valid_o && !stall_i;
  // accept when empty or when the last queued item leaves now
  assign ready_o = cnt_q == 2'd0 || (cnt_q == 2'd1 && pop);
  assign res_o   = slot_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (load_i) cnt_q <= count_i;
    else if (pop) cnt_q <= cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q[0] <= res0_i;
      slot_q[1] <= res1_i;
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) load_i |-> ready_o)
    else $error("load while queue busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue overfull");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o) else $error("stalled item dropped");

endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Feeds whole and broken format 0 midi files byte by byte into the parser
// and checks every result item against a cycle-free model of the parse.
// ---------------------------------------------------------------------------
module testbench;
  import mfep_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       eod;
  } byte_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        end_of_data = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [31:0] event_time;
  logic [19:0] event_index;
  logic [7:0]  status_byte;
  logic [6:0]  first_data, second_data, command_number, command_value;
  logic [23:0] tempo_value;
  logic [15:0] ticks_division;
  logic        last_of_run;

  midi_file_event_parser i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .data_byte_i(data_byte), .end_of_data_i(end_of_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .event_time_o(event_time), .event_index_o(event_index),
    .status_byte_o(status_byte), .first_data_o(first_data),
    .second_data_o(second_data), .tempo_value_o(tempo_value),
    .command_number_o(command_number), .command_value_o(command_value),
    .ticks_division_o(ticks_division), .last_of_run_o(last_of_run)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // parse model state
  // ---------------------------------------------------------------------
  result_t     expected_events[$];
  result_t     byte_events[$];
  phase_e      phase;
  logic [31:0] field_cnt, field_acc, abs_time, track_left;
  logic [7:0]  run_status, meta_type;
  logic [6:0]  held_first, cmd_num, cmd_val;
  logic [27:0] len_acc, skip_left;
  logic [2:0]  cmd_step;
  logic [19:0] event_count;
  bit          running_data;
  int          fails = 0;

  function automatic logic [1:0] data_bytes_for(logic [7:0] st);
    case (st[7:4])
      4'h8, 4'h9, 4'ha, 4'hb, 4'he: return 2'd2;
      4'hc, 4'hd:                   return 2'd1;
      default:                      return 2'd0;
    endcase
  endfunction

  function automatic void parser_clear();
    phase = PH_MAGIC1; field_cnt = 0; field_acc = 0; abs_time = 0;
    run_status = 0; held_first = 0; len_acc = 0; skip_left = 0;
    track_left = 32'hffff_ffff; meta_type = 0; cmd_step = 0; cmd_num = 0;
    cmd_val = 0; event_count = 0; running_data = 0;
  endfunction

  function automatic void push_result(kind_e k, logic [31:0] t, logic [19:0] idx,
                                      logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
                                      logic [23:0] tmp, logic [6:0] cn, logic [6:0] cv,
                                      logic [15:0] dv);
    result_t r;
    r.kind = k; r.event_time = t; r.event_index = idx; r.status_byte = st;
    r.first_data = d1; r.second_data = d2; r.tempo_value = tmp;
    r.command_number = cn; r.command_value = cv; r.ticks_division = dv;
    r.last_of_run = 1'b0;
    byte_events.push_back(r);
  endfunction

  function automatic logic [19:0] next_index();
    logic [19:0] idx;
    idx = event_count;
    if (event_count != 20'hfffff) event_count++;
    return idx;
  endfunction

  function automatic bit gather(logic [7:0] b, int n);
    field_acc = (field_acc << 8) | b;
    field_cnt++;
    if (field_cnt >= n) begin
      field_cnt = 0;
      return 1;
    end
    return 0;
  endfunction

  function automatic void header_bad();
    push_result(KIND_HDR_ERR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    phase = PH_DONE;
  endfunction

  function automatic void event_finished();
    field_acc = 0;
    field_cnt = 0;
    phase = (track_left == 0) ? PH_DONE : PH_DELTA;
  endfunction

  // rpn custom command pattern tracking, returns 1 when complete
  function automatic bit command_advance(logic [6:0] d1, logic [6:0] d2);
    bit ok;
    ok = 0;
    if (run_status[7:4] != CtrlNib) begin
      cmd_step = 0;
      return 0;
    end
    cmd_step++;
    case (cmd_step)
      3'd1: ok = (d1 == CcRpnMsb && d2 == CcRpnLsb);
      3'd2: begin
        ok = (d1 == CcRpnLsb);
        if (ok) cmd_num = d2;
      end
      3'd3: begin
        ok = (d1 == CcDataMsb);
        if (ok) cmd_val = d2;
      end
      3'd4: ok = (d1 == CcDataLsb);
      3'd5: ok = (d1 == CcRpnMsb && d2 == RpnNull);
      3'd6: begin
        if (d1 == CcRpnLsb && d2 == RpnNull) begin
          cmd_step = 0;
          return 1;
        end
      end
      default: ;
    endcase
    if (!ok) cmd_step = 0;
    return 0;
  endfunction

  function automatic void channel_event(logic [6:0] d2);
    logic [19:0] idx, top;
    idx = next_index();
    push_result(KIND_CHANNEL, abs_time, idx, run_status, held_first, d2, 0, 0, 0, 0);
    if (command_advance(held_first, d2)) begin
      // top index of the six-event run
      top = (idx >= 20'd5) ? idx - 20'd5 : 20'd0;
      push_result(KIND_CMD, abs_time, top, 0, 0, 0, 0, cmd_num, cmd_val, 0);
    end
    event_finished();
  endfunction

  function automatic void tempo_event();
    logic [31:0] v;
    v = field_acc;
    if (field_cnt < 3) v = v << (8 * (3 - field_cnt));
    push_result(KIND_TEMPO, abs_time, next_index(), 0, 0, 0, v[23:0], 0, 0, 0);
  endfunction

  function automatic bit length_byte(logic [7:0] b);
    len_acc = {len_acc[20:0], b[6:0]};
    return !b[7];
  endfunction

  // one accepted byte: appends its results to the expected store
  function automatic void parse_byte(logic [7:0] b, logic eod);
    logic [1:0]  need;
    logic [31:0] sum;
    byte_events.delete();
    if (phase >= PH_DELTA && phase != PH_DONE && track_left > 0) track_left--;
    case (phase)
      PH_MAGIC1: if (gather(b, 4)) begin
        if (field_acc == MagicRiff) phase = PH_RIFFSKIP;
        else if (field_acc == MagicMthd) phase = PH_HSIZE;
        else header_bad();
      end
      PH_RIFFSKIP: begin
        field_cnt++;
        if (field_cnt >= 16) begin
          field_cnt = 0;
          phase = PH_MAGIC2;
        end
      end
      PH_MAGIC2: if (gather(b, 4)) begin
        if (field_acc == MagicMthd) phase = PH_HSIZE;
        else header_bad();
      end
      PH_HSIZE: if (gather(b, 4)) begin
        if (field_acc == 32'd6) phase = PH_FORMAT;
        else header_bad();
      end
      PH_FORMAT: if (gather(b, 2)) begin
        if (field_acc[15:0] == 16'd0) phase = PH_NTRK;
        else header_bad();
      end
      PH_NTRK: if (gather(b, 2)) begin
        if (field_acc[15:0] == 16'd1) phase = PH_DIV;
        else header_bad();
      end
      PH_DIV: if (gather(b, 2)) begin
        len_acc = {12'd0, field_acc[15:0]};
        phase = PH_MTRK;
      end
      PH_MTRK: if (gather(b, 4)) begin
        if (field_acc == MagicMtrk) phase = PH_TLEN;
        else header_bad();
      end
      PH_TLEN: if (gather(b, 4)) begin
        track_left = field_acc;
        push_result(KIND_HDR_OK, 0, 0, 0, 0, 0, 0, 0, 0, len_acc[15:0]);
        len_acc = 0;
        event_finished();
      end
      PH_DELTA: begin
        field_acc = (field_acc << 7) | b[6:0];
        if (!b[7]) begin
          sum = abs_time + field_acc;
          abs_time = (sum < abs_time) ? 32'hffff_ffff : sum;
          field_acc = 0;
          phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b[7]) begin
          run_status = b;
          running_data = 0;
        end else begin
          running_data = 1;
        end
        need = data_bytes_for(run_status);
        if (need != 0) begin
          if (running_data) begin
            held_first = b[6:0];
            if (need == 1) channel_event(0);
            else phase = PH_DATA2;
          end else begin
            phase = PH_DATA1;
          end
        end else begin
          cmd_step = 0;
          if (b == StMeta) begin
            phase = PH_METATYPE;
          end else if (b == StSysex || b == StEscape) begin
            len_acc = 0;
            phase = PH_SYXLEN;
          end else begin
            push_result(KIND_UNKNOWN, abs_time, 0, b, 0, 0, 0, 0, 0, 0);
            event_finished();
          end
        end
      end
      PH_DATA1: begin
        held_first = b[6:0];
        if (data_bytes_for(run_status) == 1) channel_event(0);
        else phase = PH_DATA2;
      end
      PH_DATA2: channel_event(b[6:0]);
      PH_METATYPE: begin
        meta_type = b;
        len_acc = 0;
        phase = PH_METALEN;
      end
      PH_METALEN: if (length_byte(b)) begin
        if (meta_type == MetaEnd) begin
          push_result(KIND_END, abs_time, 0, 0, 0, 0, 0, 0, 0, 0);
          phase = PH_DONE;
        end else begin
          skip_left = len_acc;
          field_acc = 0;
          field_cnt = 0;
          if (skip_left == 0) begin
            if (meta_type == MetaTempo) tempo_event();
            event_finished();
          end else begin
            phase = PH_METASKIP;
          end
        end
      end
      PH_METASKIP: begin
        skip_left = skip_left - 28'd1;
        if (meta_type == MetaTempo && field_cnt < 3) begin
          field_acc = (field_acc << 8) | b;
          field_cnt++;
          if (field_cnt == 3) tempo_event();
        end
        if (skip_left == 0) begin
          if (meta_type == MetaTempo && field_cnt < 3) tempo_event();
          event_finished();
        end
      end
      PH_SYXLEN: if (length_byte(b)) begin
        skip_left = len_acc;
        if (skip_left == 0) event_finished();
        else phase = PH_SYXSKIP;
      end
      PH_SYXSKIP: begin
        skip_left = skip_left - 28'd1;
        if (skip_left == 0) event_finished();
      end
      default: ;
    endcase
    if (eod) begin
      if (phase < PH_DELTA && byte_events.size() == 0) header_bad();
      parser_clear();
    end
    if (byte_events.size() > 0) byte_events[byte_events.size() - 1].last_of_run = 1'b1;
    foreach (byte_events[i]) expected_events.push_back(byte_events[i]);
  endfunction

  // ---------------------------------------------------------------------
  // file building
  // ---------------------------------------------------------------------
  byte_item_t  file_bytes[$];
  logic [7:0]  track_body[$];
  logic [7:0]  hdr[$];
  bit          last_was_channel;

  function automatic void put_vlq(logic [31:0] v, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--)
      track_body.push_back({(i != 0), 7'((v >> (7 * i)) & 32'h7f)});
  endfunction

  function automatic void put_delta();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) put_vlq($urandom_range(0, 127), 1);
    else if (r < 18) put_vlq($urandom, $urandom_range(2, 4));
    else put_vlq($urandom, 5);
  endfunction

  function automatic void put_channel(logic [7:0] st, logic [7:0] d1, logic [7:0] d2,
                                      bit use_running);
    if (use_running) begin
      track_body.push_back({1'b0, d1[6:0]});
    end else begin
      track_body.push_back(st);
      track_body.push_back(d1);
    end
    if (data_bytes_for(st) == 2) track_body.push_back(d2);
  endfunction

  function automatic void put_command_run(bit corrupt);
    logic [7:0] st, a[6], d[6];
    int bad;
    st = {CtrlNib, 4'($urandom)};
    a = '{{1'b0, CcRpnMsb}, {1'b0, CcRpnLsb}, {1'b0, CcDataMsb}, {1'b0, CcDataLsb},
          {1'b0, CcRpnMsb}, {1'b0, CcRpnLsb}};
    d = '{{1'b0, CcRpnLsb}, 8'($urandom), 8'($urandom), 8'($urandom),
          {1'b0, RpnNull}, {1'b0, RpnNull}};
    bad = corrupt ? $urandom_range(0, 5) : 6;
    for (int i = 0; i < 6; i++) begin
      put_delta();
      if (i == bad) a[i] = 8'($urandom);
      put_channel(st, a[i], d[i], (i > 0 || last_was_channel) && $urandom_range(0, 1));
      if (i == 0) last_was_channel = 1;
    end
  endfunction

  function automatic void put_meta(logic [7:0] mt, int len);
    track_body.push_back(StMeta);
    track_body.push_back(mt);
    put_vlq(len, ($urandom_range(0, 9) == 0) ? 2 : 1);
    repeat (len) track_body.push_back(8'($urandom));
  endfunction

  // one random track event
  function automatic void put_random_event();
    int r;
    logic [7:0] st, u;
    r = $urandom_range(0, 99);
    put_delta();
    if (r < 40) begin
      st = 8'($urandom_range(8'h80, 8'hef));
      put_channel(st, 8'($urandom), 8'($urandom), last_was_channel && $urandom_range(0, 1));
      if (!last_was_channel || $urandom_range(0, 1)) last_was_channel = 1;
      return;
    end
    if (r < 52) begin
      put_command_run($urandom_range(0, 5) == 0);
      return;
    end
    last_was_channel = 0;
    if (r < 64) begin
      put_meta(MetaTempo, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 5) : 3);
    end else if (r < 74) begin
      u = 8'($urandom);
      if (u == MetaEnd) u = 8'h01;
      put_meta(u, $urandom_range(0, 4));
    end else if (r < 82) begin
      track_body.push_back($urandom_range(0, 1) ? StSysex : StEscape);
      r = $urandom_range(0, 4);
      put_vlq(r, 1);
      repeat (r) track_body.push_back(8'($urandom));
    end else if (r < 96) begin
      u = 8'($urandom_range(8'hf1, 8'hfe));
      if (u == StEscape) u = 8'h00;
      track_body.push_back(u);
    end else begin
      put_meta(MetaEnd, 0);
    end
  endfunction

  function automatic void put32(logic [31:0] v);
    for (int i = 3; i >= 0; i--) hdr.push_back(v[8 * i +: 8]);
  endfunction

  // header around track_body, then queue the file, eod on its last byte
  function automatic void queue_file(bit riff, int len_mode, int cut);
    int tlen;
    hdr.delete();
    if (riff) begin
      put32(MagicRiff);
      repeat (16) hdr.push_back(8'($urandom));
    end
    put32(MagicMthd);
    put32(32'd6);
    hdr.push_back(8'd0); hdr.push_back(8'd0);
    hdr.push_back(8'd0); hdr.push_back(8'd1);
    hdr.push_back(8'($urandom)); hdr.push_back(8'($urandom));
    put32(MagicMtrk);
    case (len_mode)
      0: tlen = track_body.size();
      1: tlen = $urandom_range(0, track_body.size());
      2: tlen = 0;
      default: tlen = 32'hffff_ffff;
    endcase
    put32(tlen);
    foreach (track_body[i]) hdr.push_back(track_body[i]);
    // header fault: flip a random bit somewhere in the header
    if (cut < 0) begin
      int p;
      p = $urandom_range(0, riff ? 41 : 21);
      if (!(riff && p >= 4 && p < 20)) hdr[p] = hdr[p] ^ (8'd1 << $urandom_range(0, 7));
    end
    if (cut > 0 && cut < hdr.size()) hdr = hdr[0 : cut - 1];
    foreach (hdr[i]) file_bytes.push_back('{hdr[i], (i == hdr.size() - 1)});
  endfunction

  function automatic void random_file();
    int r, n, cut;
    track_body.delete();
    last_was_channel = 0;
    n = $urandom_range(2, 10);
    repeat (n) put_random_event();
    r = $urandom_range(0, 99);
    cut = 0;
    if (r < 6) cut = -1;
    else if (r < 9) cut = $urandom_range(1, 21);
    else if (r < 14) cut = 22 + $urandom_range(1, track_body.size());
    r = $urandom_range(0, 99);
    queue_file($urandom_range(0, 9) == 0,
               (r < 80) ? 0 : (r < 88) ? 1 : (r < 92) ? 2 : 3, cut);
  endfunction

  // directed files: every event type, time saturation, header faults
  function automatic void directed_files();
    track_body.delete();
    last_was_channel = 0;
    put_vlq(32'hffff_ffff, 5);
    put_channel(8'h90, 8'hff, 8'h80, 0);
    put_vlq(32'hffff_ffff, 5);
    put_channel(8'hc3, 8'h7f, 8'h00, 0);
    put_vlq(0, 1);
    put_channel(8'hc3, 8'h05, 8'h00, 1);
    put_vlq(0, 1);
    put_meta(MetaTempo, 1);
    queue_file(0, 0, 0);
    track_body.delete();
    put_vlq(1, 1);
    put_meta(MetaTempo, 3);
    put_command_run(0);
    put_vlq(0, 1); track_body.push_back(8'hf4);
    put_vlq(0, 1); track_body.push_back(8'h12);
    put_vlq(0, 1); put_meta(MetaEnd, 0);
    track_body.push_back(8'h90);
    queue_file(1, 0, 0);
    track_body.delete();
    queue_file(0, 2, 0);
    file_bytes.push_back('{8'h00, 1'b0});
    file_bytes.push_back('{8'h00, 1'b0});
    file_bytes.push_back('{8'h00, 1'b0});
    file_bytes.push_back('{8'h00, 1'b1});
    file_bytes.push_back('{8'h4d, 1'b1});
  endfunction

  // ---------------------------------------------------------------------
  // driver, receiver and checker
  // ---------------------------------------------------------------------
  bit  running = 0;
  bit  byte_taken = 0;
  int  in_gap = 0, out_gap = 0, hold_left = 0;
  bit  hold_done = 0;
  int  quiet_cycles = 0;

  // byte driver
  always @(negedge clk_i) begin
    if (!in_valid || byte_taken) begin
      byte_taken = 0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (running && file_bytes.size() > 0) begin
        byte_item_t it;
        it = file_bytes.pop_front();
        data_byte <= it.b;
        end_of_data <= it.eod;
        in_valid <= 1'b1;
        if (file_bytes.size() > 80 && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver stall
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (running && !hold_done && file_bytes.size() < 500) begin
        hold_left = 40;
        hold_done = 1;
      end else if (file_bytes.size() > 80 && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(1, 3);
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  // acceptance, prediction, comparison and watchdog
  always @(posedge clk_i) begin
    bit moved;
    result_t e;
    moved = 0;
    if (rst_ni && in_valid && !in_stall) begin
      parse_byte(data_byte, end_of_data);
      byte_taken = 1;
      moved = 1;
    end
    if (rst_ni && out_valid && !out_stall) begin
      moved = 1;
      if (expected_events.size() == 0) begin
        $error("result item with none expected, kind %0d", kind);
        fails++;
      end else begin
        e = expected_events.pop_front();
        check_field("kind", 32'(e.kind), 32'(kind));
        check_field("event_time", e.event_time, event_time);
        check_field("event_index", 32'(e.event_index), 32'(event_index));
        check_field("status_byte", 32'(e.status_byte), 32'(status_byte));
        check_field("first_data", 32'(e.first_data), 32'(first_data));
        check_field("second_data", 32'(e.second_data), 32'(second_data));
        check_field("tempo_value", 32'(e.tempo_value), 32'(tempo_value));
        check_field("command_number", 32'(e.command_number), 32'(command_number));
        check_field("command_value", 32'(e.command_value), 32'(command_value));
        check_field("ticks_division", 32'(e.ticks_division), 32'(ticks_division));
        check_field("last_of_run", 32'(e.last_of_run), 32'(last_of_run));
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= 2000) begin
      $display("FAIL");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    parser_clear();
    directed_files();
    while (file_bytes.size() < 750) random_file();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    running = 1;
    do @(posedge clk_i);
    while (file_bytes.size() != 0 || in_valid || expected_events.size() != 0);
    repeat (20) @(posedge clk_i);
    if (expected_events.size() != 0) begin
      $error("%0d expected result items never arrived", expected_events.size());
      fails++;
    end
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
